>>> design/assert_macros.svh
// Assertion macros shared by the heart-rate monitor modules.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> design/ecg_hrm_pkg.sv
// Types and constants for the ECG heart-rate monitor.
// No dependencies; imported by every module of the block.
package ecg_hrm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 16;
    localparam int HOLD_W    = 10;
    localparam int BUZZ_W    = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int FIFO_DEPTH = 2;

    localparam logic [15:0] RATE_NUMERATOR = 16'd60000;
    localparam logic [15:0] RATE_SATURATE  = 16'hFFFF;
    localparam logic [BUZZ_W-1:0] BUZZ_OFF  = 10'd0;
    localparam logic [BUZZ_W-1:0] BUZZ_LOW  = 10'd400;
    localparam logic [BUZZ_W-1:0] BUZZ_HIGH = 10'd600;

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_HIGH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALARM_LOW   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LOW  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_HIGH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_COUNT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENV_FLOOR   = 3'd5;

    localparam logic [15:0]       RST_ALARM_HIGH  = 16'd140;
    localparam logic [15:0]       RST_ALARM_LOW   = 16'd40;
    localparam logic [15:0]       RST_WINDOW_LOW  = 16'd1800;
    localparam logic [15:0]       RST_WINDOW_HIGH = 16'd2400;
    localparam logic [HOLD_W-1:0] RST_HOLD_COUNT  = 10'd100;
    localparam logic [15:0]       RST_ENV_FLOOR   = 16'd300;

    typedef struct packed {
        logic [15:0]       alarm_rate_high;
        logic [15:0]       alarm_rate_low;
        logic [15:0]       contact_window_low;
        logic [15:0]       contact_window_high;
        logic [HOLD_W-1:0] contact_hold_count;
        logic [15:0]       envelope_floor;
    } hrm_cfg_t;

    // classified sample handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   gap;
        logic                susp;
        logic                peak;
        logic                contact;
    } hrm_item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SLOPE,
        F_PEAK
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

>>> design/ecg_hrm_fifo.sv
// Two-entry queue between the front and back of the heart-rate monitor.
// Depends on ecg_hrm_pkg for the item type and depth.
`include "assert_macros.svh"

module ecg_hrm_fifo
    import ecg_hrm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  hrm_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output hrm_item_t head_item
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    hrm_item_t         mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, !full || pop)
    `ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, pop, head_valid)

endmodule

>>> design/ecg_hrm_front.sv
// Front of the heart-rate monitor: contact qualification, delay line,
// slope envelope and peak flag. Depends on ecg_hrm_pkg.
module ecg_hrm_front
    import ecg_hrm_pkg::*;
#(
    parameter int SLOPE_LAG = 10
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  hrm_cfg_t            cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic [TIME_W-1:0]   in_time,
    input  logic                in_susp,
    input  logic                q_full,
    output logic                q_push,
    output hrm_item_t           q_item
);

    localparam int DLY_DEPTH = SLOPE_LAG + 3;

    front_state_t        state_reg, state_next;
    logic [15:0]         dly_reg [DLY_DEPTH];
    logic [TIME_W-1:0]   time_reg;
    logic                susp_reg;
    logic [HOLD_W-1:0]   contact_cnt_reg;
    logic                contact_reg;
    logic [TIME_W-1:0]   last_peak_reg;
    logic [15:0]         d_reg [3];
    logic [14:0]         half_reg [3];

    logic                accept;
    logic                in_window;
    logic [15:0]         d_next [3];
    logic [14:0]         half_next [3];
    logic [15:0]         env;
    logic [15:0]         excess [3];
    logic                peak;

    assign accept    = in_valid && in_ready;
    assign in_window = (cfg.contact_window_low < in_sample) &&
                       (in_sample < cfg.contact_window_high);

    // rising slope and running envelope at the three positions
    always_comb begin
        env = cfg.envelope_floor;
        for (int k = 0; k < 3; k++) begin
            d_next[k] = (dly_reg[k + SLOPE_LAG] > dly_reg[k]) ?
                        16'd0 : dly_reg[k] - dly_reg[k + SLOPE_LAG];
            if (d_next[k] > env) begin
                env = d_next[k];
            end
            half_next[k] = env[15:1];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            excess[k] = (d_reg[k] > {1'b0, half_reg[k]}) ? d_reg[k] - {1'b0, half_reg[k]} : 16'd0;
        end
        peak = (excess[1] > excess[0]) && (excess[1] > excess[2]);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept) state_next = F_SLOPE;
            F_SLOPE: state_next = F_PEAK;
            F_PEAK:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        q_push   = 1'b0;
        unique case (state_reg)
            F_IDLE:  in_ready = 1'b1;
            F_SLOPE: ;
            F_PEAK:  q_push = !q_full;
            default: ;
        endcase
    end

    assign q_item.sample  = dly_reg[0];
    assign q_item.gap     = time_reg - last_peak_reg;
    assign q_item.susp    = susp_reg;
    assign q_item.peak    = peak;
    assign q_item.contact = contact_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= F_IDLE;
            contact_cnt_reg <= '0;
            contact_reg     <= 1'b0;
            last_peak_reg   <= '0;
            for (int i = 0; i < DLY_DEPTH; i++) begin
                dly_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                dly_reg[0] <= in_sample;
                for (int i = 1; i < DLY_DEPTH; i++) begin
                    dly_reg[i] <= dly_reg[i - 1];
                end
                if (!in_susp) begin
                    if (in_window) begin
                        if (contact_cnt_reg == cfg.contact_hold_count) begin
                            contact_reg <= 1'b1;
                        end else begin
                            contact_cnt_reg <= contact_cnt_reg + 1'b1;
                        end
                    end else begin
                        contact_reg     <= 1'b0;
                        contact_cnt_reg <= '0;
                    end
                end
            end
            if (q_push && peak) begin
                last_peak_reg <= time_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            time_reg <= in_time;
            susp_reg <= in_susp;
        end
        if (state_reg == F_SLOPE) begin
            for (int k = 0; k < 3; k++) begin
                d_reg[k]    <= d_next[k];
                half_reg[k] <= half_next[k];
            end
        end
    end

endmodule

>>> design/ecg_hrm_back.sv
// Back of the heart-rate monitor: bit-serial rate divider, alarm buzzer
// and the registered result stage. Depends on ecg_hrm_pkg.
`include "assert_macros.svh"

module ecg_hrm_back
    import ecg_hrm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hrm_cfg_t              cfg,
    input  logic                  q_valid,
    input  hrm_item_t             q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           out_rate,
    output logic                  out_peak,
    output logic                  out_contact,
    output logic [BUZZ_W-1:0]     out_buzzer,
    output logic [SAMPLE_W-1:0]   out_word
);

    back_state_t        state_reg, state_next;
    hrm_item_t          item_reg;
    logic [15:0]        quo_reg;
    logic [15:0]        rem_reg;
    logic [3:0]         step_reg;
    logic [15:0]        rate_reg;
    logic               alarm_cnt_reg;
    logic [BUZZ_W-1:0]  buzzer_reg;
    logic               out_valid_reg;

    logic               start_div;
    logic               load_out;
    logic [16:0]        trial;
    logic               qbit;
    logic               alarm_next;
    logic [BUZZ_W-1:0]  buzzer_next;

    assign start_div = q_item.peak && (q_item.gap != '0);
    assign trial     = {rem_reg, quo_reg[15]};
    assign qbit      = (trial >= {1'b0, item_reg.gap});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_valid) state_next = start_div ? B_DIV : B_DONE;
            B_DIV:   if (step_reg == 4'd15) state_next = B_DONE;
            B_DONE:  if (!out_valid_reg || out_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            B_IDLE:  q_pop = q_valid;
            B_DIV:   ;
            B_DONE:  load_out = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // quo_reg holds the new rate once in B_DONE
    always_comb begin
        alarm_next  = alarm_cnt_reg;
        buzzer_next = buzzer_reg;
        if (item_reg.peak && !item_reg.susp) begin
            if ((quo_reg > cfg.alarm_rate_high || quo_reg < cfg.alarm_rate_low) &&
                item_reg.contact) begin
                if (alarm_cnt_reg) begin
                    buzzer_next = (buzzer_reg == BUZZ_LOW) ? BUZZ_HIGH : BUZZ_LOW;
                end else begin
                    alarm_next = 1'b1;
                end
            end else begin
                alarm_next  = 1'b0;
                buzzer_next = BUZZ_OFF;
            end
        end
        if (item_reg.susp) begin
            buzzer_next = BUZZ_OFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            rate_reg      <= '0;
            alarm_cnt_reg <= 1'b0;
            buzzer_reg    <= BUZZ_OFF;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                rate_reg      <= quo_reg;
                alarm_cnt_reg <= alarm_next;
                buzzer_reg    <= buzzer_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
            rem_reg  <= '0;
            step_reg <= '0;
            if (start_div) begin
                quo_reg <= RATE_NUMERATOR;
            end else begin
                quo_reg <= q_item.peak ? RATE_SATURATE : rate_reg;
            end
        end else if (state_reg == B_DIV) begin
            rem_reg  <= qbit ? 16'(trial - {1'b0, item_reg.gap}) : trial[15:0];
            quo_reg  <= {quo_reg[14:0], qbit};
            step_reg <= step_reg + 1'b1;
        end
        if (load_out) begin
            out_rate    <= quo_reg;
            out_peak    <= item_reg.peak;
            out_contact <= item_reg.contact;
            out_buzzer  <= buzzer_next;
            out_word    <= {item_reg.sample[15] | item_reg.contact, item_reg.sample[14:0]};
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_IMPLIES(a_buzzer_values, aclk, aresetn, 1'b1,
        buzzer_reg == BUZZ_OFF || buzzer_reg == BUZZ_LOW || buzzer_reg == BUZZ_HIGH)
    `ASSERT_IMPLIES(a_buzzer_needs_alarm, aclk, aresetn, !alarm_cnt_reg, buzzer_reg == BUZZ_OFF)
    `ASSERT_NEXT(a_div_length, aclk, aresetn, state_reg == B_DIV && step_reg != 4'd15,
        state_reg == B_DIV)

endmodule

>>> design/ecg_heart_rate_monitor.sv
// ECG heart-rate monitor top level: config registers, front, queue, back.
// Front: accept, slope/envelope, then peak and push (held while the queue is full).
// Back: pops one item at a time; on a peak with nonzero interval it runs the
//   one-bit-per-cycle 16-step rate divider, then loads the output register.
// Reset: synchronous, active low; clears control state, loads register defaults.
module ecg_heart_rate_monitor
    import ecg_hrm_pkg::*;
#(
    parameter int SLOPE_LAG = 10
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]           cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample[15:0], time_ms[31:16], suspend[32], zero pad[39:33]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // heart_rate[15:0], peak_seen[16], contact_ok[17], buzzer_compare[27:18],
    // encoded_word[43:28], zero pad[47:44]
    output logic [M_TDATA_W-1:0]  m_tdata
);

    hrm_cfg_t            cfg_reg;
    logic                q_push, q_full, q_pop, q_valid;
    hrm_item_t           push_item, head_item;
    logic [15:0]         rate;
    logic                peak, contact;
    logic [BUZZ_W-1:0]   buzzer;
    logic [SAMPLE_W-1:0] word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_rate_high     <= RST_ALARM_HIGH;
            cfg_reg.alarm_rate_low      <= RST_ALARM_LOW;
            cfg_reg.contact_window_low  <= RST_WINDOW_LOW;
            cfg_reg.contact_window_high <= RST_WINDOW_HIGH;
            cfg_reg.contact_hold_count  <= RST_HOLD_COUNT;
            cfg_reg.envelope_floor      <= RST_ENV_FLOOR;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ALARM_HIGH:  cfg_reg.alarm_rate_high     <= cfg_wdata;
                CFG_ALARM_LOW:   cfg_reg.alarm_rate_low      <= cfg_wdata;
                CFG_WINDOW_LOW:  cfg_reg.contact_window_low  <= cfg_wdata;
                CFG_WINDOW_HIGH: cfg_reg.contact_window_high <= cfg_wdata;
                CFG_HOLD_COUNT:  cfg_reg.contact_hold_count  <= cfg_wdata[HOLD_W-1:0];
                CFG_ENV_FLOOR:   cfg_reg.envelope_floor      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ecg_hrm_front #(
        .SLOPE_LAG (SLOPE_LAG)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[15:0]),
        .in_time   (s_tdata[31:16]),
        .in_susp   (s_tdata[32]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    ecg_hrm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item)
    );

    ecg_hrm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_rate    (rate),
        .out_peak    (peak),
        .out_contact (contact),
        .out_buzzer  (buzzer),
        .out_word    (word)
    );

    assign m_tdata = {4'b0, word, buzzer, contact, peak, rate};

endmodule
